// ===== hw/rtl/maze_dfs_path_search_macros.svh =====
// ----------------------------------------------------------------------------
// maze dfs path search assertion macros
// concurrent assertion shorthands on clk with synchronous active-low rst_n
// ----------------------------------------------------------------------------
`ifndef MAZE_DFS_PATH_SEARCH_MACROS_SVH
`define MAZE_DFS_PATH_SEARCH_MACROS_SVH

// property that holds at every clock edge outside reset
`define MDFS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define MDFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MDFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mdfs_pkg
// shared types and constants of the maze dfs path search block
// ----------------------------------------------------------------------------
package mdfs_pkg;

  localparam int GRID_W   = 6;
  localparam int ROWCOL_W = 5;
  localparam int LEN_W    = 11;
  localparam int N_DIRS   = 8;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST = 6'd32;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CELL_OPEN = 2'd0,
    CELL_WALL = 2'd1,
    CELL_PATH = 2'd2,
    CELL_DEAD = 2'd3
  } cell_code_t;

  typedef enum logic {
    RES_READ   = 1'b0,
    RES_SEARCH = 1'b1
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_GOAL,
    ST_START,
    ST_SCAN,
    ST_POP,
    ST_REPORT
  } state_t;

  // neighbour offsets, two's complement: E, SE, S, SW, W, NW, N, NE
  localparam logic [1:0] DIR_DR [N_DIRS] = '{
    2'b00, 2'b01, 2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b11
  };
  localparam logic [1:0] DIR_DC [N_DIRS] = '{
    2'b01, 2'b01, 2'b00, 2'b11, 2'b11, 2'b11, 2'b00, 2'b01
  };

endpackage

// ===== hw/rtl/mdfs_ram.sv =====
// ----------------------------------------------------------------------------
// mdfs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mdfs_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/maze_dfs_path_search.sv =====
// ----------------------------------------------------------------------------
// maze_dfs_path_search
// eight-neighbour depth-first maze search over a cell memory with a path stack
// ----------------------------------------------------------------------------
// The maze lives in a cell memory of 2 bits per cell (open, wall, on path,
// dead end), addressed {row, col}, and the walk keeps its cell addresses in a
// separate stack memory; both have one write and one registered read port.
// A cell write transaction is taken every cycle while the block is idle, no
// read answer is in flight and no answer waits stalled in the result
// register, and returns nothing. A cell read goes through the memory read,
// then the result register, so in_stall rises after each read; cells
// outside the grid read as wall. A search transaction holds in_stall high
// until its answer is loaded: a sweep over all N cells turns old path and
// dead-end marks back to open (N = 4**ceil(log2(MAX_DIM)), 1024 by default),
// the goal is forced open and the start pushed, then each step of the walk
// reads neighbours through the single cell read port (one per direction,
// restarting at east each step), a backtrack adds one stack read, and the
// report state loads the answer. After reset a clearing pass writes every
// cell open while in_stall is held high; cfg writes are taken at any
// time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "maze_dfs_path_search_macros.svh"

module maze_dfs_path_search #(
  parameter int MAX_DIM     = 32,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [mdfs_pkg::GRID_W-1:0]   cfg_wr_data,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [mdfs_pkg::ROWCOL_W-1:0] in_row,
  input  logic [mdfs_pkg::ROWCOL_W-1:0] in_col,
  input  logic                          in_wall,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [1:0]                    out_cell_status,
  output logic                          out_found,
  output logic [mdfs_pkg::LEN_W-1:0]    out_path_length
);

  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int AW      = 2 * DIM_W;
  localparam int N_CELLS = 1 << AW;
  localparam int M_W     = DIM_W + 1;
  localparam int NB_W    = DIM_W + 2;
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int CNT_W   = SP_W + 1;
  localparam int LEN_W   = mdfs_pkg::LEN_W;

  mdfs_pkg::state_t state_r, state_nxt;

  logic [mdfs_pkg::GRID_W-1:0] grid_size_r;
  logic [6:0]                  g_ext;
  logic [6:0]                  m_full;
  logic [M_W-1:0]              m;
  logic [DIM_W-1:0]            m_less1;
  logic [AW-1:0]               goal_addr;

  // sweep / clear address counter, one bit wider to reach N_CELLS
  logic [AW:0]       addr_cnt_r;
  // outstanding cell read during sweep and neighbour scan
  logic              pend_r;
  logic [AW-1:0]     pend_addr_r;
  logic [3:0]        dir_r;
  logic [AW-1:0]     top_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              found_r;
  logic [LEN_W-1:0]  len_r;
  logic              rd_pend_r;
  logic              rd_wall_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [1:0]        out_status_r;
  logic              out_found_r;
  logic [LEN_W-1:0]  out_len_r;

  // memory ports
  logic              cell_we;
  logic [AW-1:0]     cell_waddr;
  logic [1:0]        cell_wdata;
  logic [AW-1:0]     cell_raddr;
  logic [1:0]        cell_rdata;
  logic              stk_we;
  logic [SP_W-1:0]   stk_waddr;
  logic [AW-1:0]     stk_wdata;
  logic [SP_W-1:0]   stk_raddr;
  logic [AW-1:0]     stk_rdata;

  // input decode
  logic              in_acc;
  mdfs_pkg::cmd_t    cmd;
  logic              wr_in_store;
  logic              rd_in_grid;
  logic [AW-1:0]     in_addr;

  // neighbour scan
  logic [DIM_W-1:0]  top_row;
  logic [DIM_W-1:0]  top_col;
  logic [1:0]        dr;
  logic [1:0]        dc;
  logic [NB_W-1:0]   nr;
  logic [NB_W-1:0]   nc;
  logic              nb_ok;
  logic [AW-1:0]     nb_addr;
  logic              cnt_room;
  logic              take;
  logic              issue;
  logic              dead;
  logic              last_pop;
  logic              out_free;

  // state and result flags
  logic              scan_st;
  logic              report_load;
  logic              search_out;

  mdfs_ram #(
    .DEPTH  (N_CELLS),
    .DATA_W (2)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  mdfs_ram #(
    .DEPTH  (STACK_DEPTH),
    .DATA_W (AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // side in use: zero acts as one, large values clamp to MAX_DIM
  assign g_ext = {1'b0, grid_size_r};

  always_comb begin
    if (g_ext == 7'd0) begin
      m_full = 7'd1;
    end else if (g_ext > 7'(MAX_DIM)) begin
      m_full = 7'(MAX_DIM);
    end else begin
      m_full = g_ext;
    end
  end

  assign m         = M_W'(m_full);
  assign m_less1   = DIM_W'(m - M_W'(1));
  assign goal_addr = {m_less1, m_less1};

  // command decode
  assign cmd         = mdfs_pkg::cmd_t'(in_command);
  assign in_acc      = in_valid && !in_stall;
  assign wr_in_store = ({2'b00, in_row} < 7'(MAX_DIM)) && ({2'b00, in_col} < 7'(MAX_DIM));
  assign rd_in_grid  = ({2'b00, in_row} < 7'(m)) && ({2'b00, in_col} < 7'(m));
  assign in_addr     = {DIM_W'(in_row), DIM_W'(in_col)};

  // result register is free or empties at this edge
  assign out_free = !out_valid_r || !out_stall;

  // commands wait while busy, while a read answer is in flight, or while
  // the result register is blocked
  assign in_stall = (state_r != mdfs_pkg::ST_IDLE) || rd_pend_r || (out_valid_r && out_stall);

  // neighbour of the stack top in direction dir_r
  assign top_row = top_r[AW-1:DIM_W];
  assign top_col = top_r[DIM_W-1:0];
  assign dr      = mdfs_pkg::DIR_DR[dir_r[2:0]];
  assign dc      = mdfs_pkg::DIR_DC[dir_r[2:0]];
  assign nr      = {2'b00, top_row} + {{DIM_W{dr[1]}}, dr};
  assign nc      = {2'b00, top_col} + {{DIM_W{dc[1]}}, dc};
  // a step off the top or left edge wraps to a large value and fails too
  assign nb_ok   = (nr < NB_W'(m)) && (nc < NB_W'(m));
  assign nb_addr = {nr[DIM_W-1:0], nc[DIM_W-1:0]};

  // scan decisions: the read for a direction returns in the cycle after issue
  assign cnt_room = cnt_r < CNT_W'(STACK_DEPTH);
  assign take     = (state_r == mdfs_pkg::ST_SCAN) && pend_r && cnt_room &&
                    (mdfs_pkg::cell_code_t'(cell_rdata) == mdfs_pkg::CELL_OPEN);
  assign issue    = (state_r == mdfs_pkg::ST_SCAN) && !take && !dir_r[3];
  assign dead     = (state_r == mdfs_pkg::ST_SCAN) && !take && dir_r[3];
  assign last_pop = cnt_r == CNT_W'(1);

  assign scan_st     = state_r == mdfs_pkg::ST_SCAN;
  assign report_load = (state_r == mdfs_pkg::ST_REPORT) && out_free;
  assign search_out  = out_valid_r && (out_kind_r == mdfs_pkg::RES_SEARCH);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdfs_pkg::ST_CLEAR: begin
        if (addr_cnt_r == (AW+1)'(N_CELLS - 1)) begin
          state_nxt = mdfs_pkg::ST_IDLE;
        end
      end
      mdfs_pkg::ST_IDLE: begin
        if (in_acc && cmd == mdfs_pkg::CMD_SEARCH) begin
          state_nxt = mdfs_pkg::ST_SWEEP;
        end
      end
      mdfs_pkg::ST_SWEEP: begin
        if (addr_cnt_r == (AW+1)'(N_CELLS)) begin
          state_nxt = mdfs_pkg::ST_GOAL;
        end
      end
      mdfs_pkg::ST_GOAL: begin
        state_nxt = mdfs_pkg::ST_START;
      end
      mdfs_pkg::ST_START: begin
        if (goal_addr == '0) begin
          state_nxt = mdfs_pkg::ST_REPORT;
        end else begin
          state_nxt = mdfs_pkg::ST_SCAN;
        end
      end
      mdfs_pkg::ST_SCAN: begin
        if (take && pend_addr_r == goal_addr) begin
          state_nxt = mdfs_pkg::ST_REPORT;
        end else if (dead && last_pop) begin
          state_nxt = mdfs_pkg::ST_REPORT;
        end else if (dead) begin
          state_nxt = mdfs_pkg::ST_POP;
        end
      end
      mdfs_pkg::ST_POP: begin
        state_nxt = mdfs_pkg::ST_SCAN;
      end
      mdfs_pkg::ST_REPORT: begin
        if (out_free) begin
          state_nxt = mdfs_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // memory port control
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = mdfs_pkg::CELL_OPEN;
    cell_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = '0;
    unique case (state_r)
      mdfs_pkg::ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = addr_cnt_r[AW-1:0];
        cell_wdata = mdfs_pkg::CELL_OPEN;
      end
      mdfs_pkg::ST_IDLE: begin
        cell_raddr = in_addr;
        if (in_acc && cmd == mdfs_pkg::CMD_WRITE && wr_in_store) begin
          cell_we    = 1'b1;
          cell_waddr = in_addr;
          cell_wdata = {1'b0, in_wall};
        end
      end
      mdfs_pkg::ST_SWEEP: begin
        cell_raddr = addr_cnt_r[AW-1:0];
        // path and dead-end marks go back to open
        if (pend_r && cell_rdata[1]) begin
          cell_we    = 1'b1;
          cell_waddr = pend_addr_r;
          cell_wdata = mdfs_pkg::CELL_OPEN;
        end
      end
      mdfs_pkg::ST_GOAL: begin
        cell_we    = 1'b1;
        cell_waddr = goal_addr;
        cell_wdata = mdfs_pkg::CELL_OPEN;
      end
      mdfs_pkg::ST_START: begin
        cell_we    = 1'b1;
        cell_waddr = '0;
        cell_wdata = mdfs_pkg::CELL_PATH;
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = '0;
      end
      mdfs_pkg::ST_SCAN: begin
        if (take) begin
          cell_we    = 1'b1;
          cell_waddr = pend_addr_r;
          cell_wdata = mdfs_pkg::CELL_PATH;
          stk_we     = 1'b1;
          stk_waddr  = cnt_r[SP_W-1:0];
          stk_wdata  = pend_addr_r;
        end else if (issue) begin
          cell_raddr = nb_addr;
        end else begin
          // dead end: mark the top and fetch the entry below it
          cell_we    = 1'b1;
          cell_waddr = top_r;
          cell_wdata = mdfs_pkg::CELL_DEAD;
          stk_raddr  = SP_W'(cnt_r - CNT_W'(2));
        end
      end
      mdfs_pkg::ST_POP: begin
        cell_raddr = '0;
      end
      mdfs_pkg::ST_REPORT: begin
        cell_raddr = '0;
      end
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdfs_pkg::ST_CLEAR;
      grid_size_r <= mdfs_pkg::GRID_SIZE_RST;
      addr_cnt_r  <= '0;
      pend_r      <= 1'b0;
      dir_r       <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= in_acc && cmd == mdfs_pkg::CMD_READ;
      if (cfg_wr_en) begin
        grid_size_r <= cfg_wr_data;
      end

      unique case (state_r)
        mdfs_pkg::ST_CLEAR: begin
          addr_cnt_r <= addr_cnt_r + (AW+1)'(1);
        end
        mdfs_pkg::ST_IDLE: begin
          addr_cnt_r <= '0;
          pend_r     <= 1'b0;
        end
        mdfs_pkg::ST_SWEEP: begin
          addr_cnt_r  <= addr_cnt_r + (AW+1)'(1);
          pend_r      <= !addr_cnt_r[AW];
          pend_addr_r <= addr_cnt_r[AW-1:0];
        end
        mdfs_pkg::ST_GOAL: begin
          pend_r <= 1'b0;
        end
        mdfs_pkg::ST_START: begin
          cnt_r   <= CNT_W'(1);
          top_r   <= '0;
          dir_r   <= '0;
          pend_r  <= 1'b0;
          found_r <= (goal_addr == '0);
          len_r   <= LEN_W'(1);
        end
        mdfs_pkg::ST_SCAN: begin
          if (take) begin
            cnt_r  <= cnt_r + CNT_W'(1);
            top_r  <= pend_addr_r;
            dir_r  <= '0;
            pend_r <= 1'b0;
            if (pend_addr_r == goal_addr) begin
              found_r <= 1'b1;
              len_r   <= LEN_W'(cnt_r + CNT_W'(1));
            end
          end else if (issue) begin
            pend_r      <= nb_ok;
            pend_addr_r <= nb_addr;
            dir_r       <= dir_r + 4'd1;
          end else begin
            cnt_r  <= cnt_r - CNT_W'(1);
            dir_r  <= '0;
            pend_r <= 1'b0;
            if (last_pop) begin
              found_r <= 1'b0;
              len_r   <= '0;
            end
          end
        end
        mdfs_pkg::ST_POP: begin
          top_r  <= stk_rdata;
          dir_r  <= '0;
          pend_r <= 1'b0;
        end
        mdfs_pkg::ST_REPORT: begin
          pend_r <= 1'b0;
        end
      endcase

      // result register
      if (rd_pend_r) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= mdfs_pkg::RES_READ;
        out_status_r <= rd_wall_r ? mdfs_pkg::CELL_WALL : cell_rdata;
        out_found_r  <= 1'b0;
        out_len_r    <= '0;
      end else if (state_r == mdfs_pkg::ST_REPORT && out_free) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= mdfs_pkg::RES_SEARCH;
        out_status_r <= mdfs_pkg::CELL_OPEN;
        out_found_r  <= found_r;
        out_len_r    <= len_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // outside-grid flag travels with the read transaction
  always_ff @(posedge clk) begin
    rd_wall_r <= !rd_in_grid;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_cell_status = out_status_r;
  assign out_found       = out_found_r;
  assign out_path_length = out_len_r;

  // assertions
  `MDFS_ASSERT_ALWAYS(a_stack_bound, cnt_r <= CNT_W'(STACK_DEPTH), "stack count above depth")
  `MDFS_ASSERT_IMP(a_scan_nonempty, scan_st, cnt_r != '0, "scan on empty stack")
  `MDFS_ASSERT_IMP(a_read_slot_free, rd_pend_r, !out_valid_r, "read answer while result full")
  `MDFS_ASSERT_NXT(a_report_loads, report_load, search_out, "search answer not loaded")

endmodule

// ===== sim/tb_maze_dfs_path_search.sv =====
// ----------------------------------------------------------------------------
// tb_maze_dfs_path_search
// self-checking bench for the eight-neighbour depth-first maze search block
// ----------------------------------------------------------------------------
// Drives cell write, cell read and search transactions over the valid/stall
// command channel and keeps its own copy of the cell memory and grid size.
// Every accepted read or search transaction gets a predicted answer, and
// every answer leaving the block is compared against the oldest prediction.
// A directed part covers power-on contents, reads outside the grid, the
// one-cell grid, a start walled in but for the goal and the grid size limits.
// Mostly small random mazes with searches and follow-up reads make up the rest.
// ----------------------------------------------------------------------------
module tb_maze_dfs_path_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM         = 32;
  localparam int TRAIL_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2_000_000;

  // neighbour order: E, SE, S, SW, W, NW, N, NE with row growing downward
  localparam int ROW_STEP [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
  localparam int COL_STEP [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

  typedef struct {
    mdfs_pkg::res_kind_t         kind;
    mdfs_pkg::cell_code_t        status;
    logic                        found;
    logic [mdfs_pkg::LEN_W-1:0]  length;
  } answer_t;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          cfg_wr_en       = 1'b0;
  logic [mdfs_pkg::GRID_W-1:0]   cfg_wr_data     = '0;
  logic                          in_valid        = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_command      = '0;
  logic [mdfs_pkg::ROWCOL_W-1:0] in_row          = '0;
  logic [mdfs_pkg::ROWCOL_W-1:0] in_col          = '0;
  logic                          in_wall         = 1'b0;
  logic                          out_valid;
  logic                          out_stall       = 1'b0;
  logic                          out_result_kind;
  logic [1:0]                    out_cell_status;
  logic                          out_found;
  logic [mdfs_pkg::LEN_W-1:0]    out_path_length;

  // shadow of the block: cell memory and grid size register
  mdfs_pkg::cell_code_t          maze_cells [DIM*DIM];
  logic [mdfs_pkg::GRID_W-1:0]   grid_reg;
  answer_t                       pending_answers [$];

  int                  item_count     = 0;
  int                  mismatch_count = 0;
  int                  cycle_count    = 0;
  int                  big_phases     = 0;
  bit                  in_gaps_on     = 1'b1;
  bit                  out_stalls_on  = 1'b1;
  int                  stall_left     = 0;
  int                  stall_pick;

  maze_dfs_path_search #(
    .MAX_DIM     (DIM),
    .STACK_DEPTH (TRAIL_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_wall         (in_wall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_cell_status (out_cell_status),
    .out_found       (out_found),
    .out_path_length (out_path_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, also covers the clearing pass after reset
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // mostly no gap, short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sizes 0 and above the store behave as the nearest legal size
  function automatic int side_of(input logic [mdfs_pkg::GRID_W-1:0] g);
    if (g == 0) return 1;
    if (g > DIM) return DIM;
    return int'(g);
  endfunction

  // depth-first walk over the shadow cells, marks path and dead ends
  task automatic walk_maze(output logic reached,
                           output logic [mdfs_pkg::LEN_W-1:0] len);
    int trail [TRAIL_DEPTH];
    int depth, m, goal, top, r, c, nr, nc, idx, d;
    bit taken;
    m    = side_of(grid_reg);
    goal = (m - 1) * DIM + (m - 1);
    // old marks go back to open, start and goal are forced open
    foreach (maze_cells[i])
      if (maze_cells[i] == mdfs_pkg::CELL_PATH || maze_cells[i] == mdfs_pkg::CELL_DEAD)
        maze_cells[i] = mdfs_pkg::CELL_OPEN;
    maze_cells[0]    = mdfs_pkg::CELL_OPEN;
    maze_cells[goal] = mdfs_pkg::CELL_OPEN;
    trail[0]      = 0;
    depth         = 1;
    maze_cells[0] = mdfs_pkg::CELL_PATH;
    reached       = (goal == 0);
    while (depth > 0 && !reached) begin
      top   = trail[depth-1];
      r     = top / DIM;
      c     = top % DIM;
      taken = 1'b0;
      // scan restarts at east on every step
      for (d = 0; d < 8 && !taken; d++) begin
        nr = r + ROW_STEP[d];
        nc = c + COL_STEP[d];
        if (nr >= 0 && nc >= 0 && nr < m && nc < m) begin
          idx = nr * DIM + nc;
          if (maze_cells[idx] == mdfs_pkg::CELL_OPEN && depth < TRAIL_DEPTH) begin
            trail[depth]    = idx;
            depth++;
            maze_cells[idx] = mdfs_pkg::CELL_PATH;
            taken           = 1'b1;
            if (idx == goal) reached = 1'b1;
          end
        end
      end
      // dead end only when nothing was pushed from this cell
      if (!taken) begin
        maze_cells[top] = mdfs_pkg::CELL_DEAD;
        depth--;
      end
    end
    len = reached ? mdfs_pkg::LEN_W'(depth) : '0;
  endtask

  // apply one accepted transaction to the shadow and queue its answer
  task automatic predict_item(input mdfs_pkg::cmd_t cmd, input int row, input int col,
                              input bit wall);
    answer_t ans;
    int m;
    m = side_of(grid_reg);
    ans.kind   = mdfs_pkg::RES_READ;
    ans.status = mdfs_pkg::CELL_OPEN;
    ans.found  = 1'b0;
    ans.length = '0;
    case (cmd)
      mdfs_pkg::CMD_WRITE: begin
        maze_cells[row*DIM + col] = wall ? mdfs_pkg::CELL_WALL : mdfs_pkg::CELL_OPEN;
      end
      mdfs_pkg::CMD_READ: begin
        // anything outside the grid in use reads as wall
        ans.status = (row < m && col < m) ? maze_cells[row*DIM + col] : mdfs_pkg::CELL_WALL;
        pending_answers.push_back(ans);
      end
      mdfs_pkg::CMD_SEARCH: begin
        ans.kind = mdfs_pkg::RES_SEARCH;
        walk_maze(ans.found, ans.length);
        pending_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endtask

  // one command transaction; valid stays high into the next one unless a gap
  task automatic send_cmd(input mdfs_pkg::cmd_t cmd, input int row, input int col,
                          input bit wall);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_row     <= mdfs_pkg::ROWCOL_W'(row);
    in_col     <= mdfs_pkg::ROWCOL_W'(col);
    in_wall    <= wall;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(cmd, row, col, wall);
    if (cmd != mdfs_pkg::CMD_NOP) item_count++;
  endtask

  // drain all answers and let a trailing write or ignored command finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_grid(input int value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mdfs_pkg::GRID_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    grid_reg     = mdfs_pkg::GRID_W'(value);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n || !out_stalls_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = pick_gap();
      out_stall  <= (stall_pick > 0);
      stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
    end
  end

  // answer checker, oldest prediction first
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected answer: kind %0d status %0d found %0d length %0d",
                   out_result_kind, out_cell_status, out_found, out_path_length);
      end else begin
        want = pending_answers.pop_front();
        if (out_result_kind !== want.kind || out_cell_status !== want.status ||
            out_found !== want.found || out_path_length !== want.length) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("answer mismatch: exp kind %0d status %0d found %0d length %0d, %s",
                     want.kind, want.status, want.found, want.length,
                     $sformatf("got kind %0d status %0d found %0d length %0d",
                               out_result_kind, out_cell_status, out_found,
                               out_path_length));
        end
      end
    end
  end

  // cells come up open after the clearing pass, default size is the full store
  task automatic test_power_on_reads();
    send_cmd(mdfs_pkg::CMD_READ, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 31, 31, 1'b0);
  endtask

  // writes, reads back and an ignored command
  task automatic test_cell_access();
    send_cmd(mdfs_pkg::CMD_WRITE, 0, 1, 1'b1);
    send_cmd(mdfs_pkg::CMD_WRITE, 31, 31, 1'b1);
    send_cmd(mdfs_pkg::CMD_WRITE, 12, 20, 1'b1);
    send_cmd(mdfs_pkg::CMD_READ, 0, 1, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 31, 31, 1'b0);
    send_cmd(mdfs_pkg::CMD_NOP, 31, 31, 1'b1);
    send_cmd(mdfs_pkg::CMD_READ, 12, 20, 1'b0);
  endtask

  // forced goal, one-cell grid, size limits, start walled in but for the goal, stale marks
  task automatic test_search_extremes();
    // goal holds a wall that the search forces open
    send_cmd(mdfs_pkg::CMD_SEARCH, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 31, 31, 1'b0);
    // start is the goal
    set_grid(1);
    send_cmd(mdfs_pkg::CMD_SEARCH, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 1, 0, 1'b0);
    // size zero behaves as one
    set_grid(0);
    send_cmd(mdfs_pkg::CMD_SEARCH, 0, 0, 1'b0);
    // start walled in but for the goal, write outside the grid is kept
    set_grid(2);
    send_cmd(mdfs_pkg::CMD_WRITE, 1, 0, 1'b1);
    send_cmd(mdfs_pkg::CMD_WRITE, 1, 1, 1'b1);
    send_cmd(mdfs_pkg::CMD_WRITE, 5, 5, 1'b1);
    send_cmd(mdfs_pkg::CMD_SEARCH, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 31, 31, 1'b0);
    // oversize behaves as the full store
    set_grid(63);
    send_cmd(mdfs_pkg::CMD_READ, 5, 5, 1'b0);
    send_cmd(mdfs_pkg::CMD_SEARCH, 0, 0, 1'b0);
    send_cmd(mdfs_pkg::CMD_READ, 1, 1, 1'b0);
  endtask

  // random mazes, mostly small, each followed by searches and reads
  task automatic test_random_mazes(input int target);
    int roll, g, m, density, r, c, n, k, passes;
    while (item_count < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) g = 1;
      else if (roll < 8) g = 0;
      else if (roll < 13 && big_phases < 6) begin
        g = $urandom_range(0, 1) ? DIM : $urandom_range(DIM + 1, 63);
        big_phases++;
      end else g = $urandom_range(2, 8);
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      set_grid(g);
      m       = side_of(mdfs_pkg::GRID_W'(g));
      density = $urandom_range(10, 55);
      if ($urandom_range(0, 9) < 8) begin
        // lay out the maze, whole grid when small, scattered cells when large
        if (m <= 8) begin
          for (r = 0; r < m; r++)
            for (c = 0; c < m; c++)
              send_cmd(mdfs_pkg::CMD_WRITE, r, c, $urandom_range(0, 99) < density);
        end else begin
          for (k = 0; k < 60; k++)
            send_cmd(mdfs_pkg::CMD_WRITE, $urandom_range(0, m - 1),
                     $urandom_range(0, m - 1), $urandom_range(0, 99) < density);
        end
        passes = $urandom_range(1, 2);
        for (k = 0; k < passes; k++) begin
          send_cmd(mdfs_pkg::CMD_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31),
                   $urandom_range(0, 1));
          n = $urandom_range(2, 6);
          repeat (n) begin
            if ($urandom_range(0, 7) == 0)
              send_cmd(mdfs_pkg::CMD_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1));
            else
              send_cmd(mdfs_pkg::CMD_READ, $urandom_range(0, m - 1),
                       $urandom_range(0, m - 1), $urandom_range(0, 1));
          end
          // a few edits before searching again over the stale marks
          if (k + 1 < passes)
            repeat ($urandom_range(1, 4))
              send_cmd(mdfs_pkg::CMD_WRITE, $urandom_range(0, m - 1),
                       $urandom_range(0, m - 1), $urandom_range(0, 1));
        end
      end else begin
        // noise: any command on any cell of the store
        repeat ($urandom_range(10, 25))
          send_cmd(mdfs_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    foreach (maze_cells[i]) maze_cells[i] = mdfs_pkg::CELL_OPEN;
    grid_reg = mdfs_pkg::GRID_SIZE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_power_on_reads();
    test_cell_access();
    test_search_extremes();
    test_random_mazes(500);
    // drain, then give the block time to show any stray transaction
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
